// ===== rtl/core/rmq_pkg.sv =====
// Shared types and constants of the rotation matrix to quaternion converter.
package rmq_pkg;

  localparam int ELEM_W = 18;
  localparam int THR_W  = 17;
  localparam int NUM_W  = 19;

  typedef logic [1:0] branch_t;

  localparam branch_t BR_TRACE = 2'd0;
  localparam branch_t BR_X     = 2'd1;
  localparam branch_t BR_Y     = 2'd2;
  localparam branch_t BR_Z     = 2'd3;

  localparam logic signed [ELEM_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [ELEM_W-1:0] OUT_MIN = 18'sh20000;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Top level: pipelined rotation matrix to unit quaternion conversion.
// A beat passes the input register, the square-root stages, the dividend
// register, the quotient stages and the output register, one root or quotient
// bit per stage. Throughput: one beat per cycle; the whole pipeline holds only
// while a finished result waits at a stalled output.
// Reset (rst_n low at a clock edge) empties the pipeline and sets
// trace_threshold to 1.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [THR_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_elem_00,
  input  logic signed [ELEM_W-1:0] in_elem_01,
  input  logic signed [ELEM_W-1:0] in_elem_02,
  input  logic signed [ELEM_W-1:0] in_elem_10,
  input  logic signed [ELEM_W-1:0] in_elem_11,
  input  logic signed [ELEM_W-1:0] in_elem_12,
  input  logic signed [ELEM_W-1:0] in_elem_20,
  input  logic signed [ELEM_W-1:0] in_elem_21,
  input  logic signed [ELEM_W-1:0] in_elem_22,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_quat_w,
  output logic signed [ELEM_W-1:0] out_quat_x,
  output logic signed [ELEM_W-1:0] out_quat_y,
  output logic signed [ELEM_W-1:0] out_quat_z,
  output logic [1:0]               out_branch_taken,
  output logic                     out_bad_input
);

  // Width of the trace and of the square-root argument, with headroom for
  // one plus three full-scale diagonal elements.
  localparam int BASE_W = (FRAC_BITS + 1 > ELEM_W + 2) ? FRAC_BITS + 1 : ELEM_W + 2;
  localparam int ARG_W  = BASE_W + 2;
  // Radicand is the positive argument shifted up by FRAC_BITS, padded to even.
  localparam int SQ_W   = (ARG_W - 1 + FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  // Dividend (mag << FRAC_BITS) + r, and the number of quotient bits kept.
  localparam int DIV_W  = NUM_W + FRAC_BITS + 2;
  localparam int Q_W    = ELEM_W + 1;
  localparam int CMP_W  = DIV_W + Q_W + SQ_W + 2;

  // The whole pipeline moves together unless a result is held at the output.
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Branch selection, argument and the three numerators.
  // ---------------------------------------------------------------------
  logic signed [ARG_W-1:0] one_c, tr_c, arg_c;
  logic signed [ARG_W-1:0] e00_c, e11_c, e22_c;
  logic signed [NUM_W-1:0] n_c [0:2];
  branch_t                 br_c;
  logic                    bad_c;

  function automatic logic signed [NUM_W-1:0] ext_add(
    input logic signed [ELEM_W-1:0] a,
    input logic signed [ELEM_W-1:0] b,
    input logic                     sub
  );
    logic signed [NUM_W-1:0] ax, bx;
    ax = NUM_W'(a);
    bx = NUM_W'(b);
    return sub ? ax - bx : ax + bx;
  endfunction

  always_comb begin
    one_c = ARG_W'(1) <<< FRAC_BITS;
    e00_c = ARG_W'(in_elem_00);
    e11_c = ARG_W'(in_elem_11);
    e22_c = ARG_W'(in_elem_22);
    tr_c  = one_c + e00_c + e11_c + e22_c;
    if (tr_c > $signed({{(ARG_W-THR_W){1'b0}}, thr_r})) begin
      br_c   = BR_TRACE;
      arg_c  = tr_c;
      n_c[0] = ext_add(in_elem_21, in_elem_12, 1'b1);
      n_c[1] = ext_add(in_elem_02, in_elem_20, 1'b1);
      n_c[2] = ext_add(in_elem_10, in_elem_01, 1'b1);
    end else if (in_elem_00 > in_elem_11 && in_elem_00 > in_elem_22) begin
      br_c   = BR_X;
      arg_c  = one_c + e00_c - e11_c - e22_c;
      n_c[0] = ext_add(in_elem_21, in_elem_12, 1'b1);
      n_c[1] = ext_add(in_elem_01, in_elem_10, 1'b0);
      n_c[2] = ext_add(in_elem_02, in_elem_20, 1'b0);
    end else if (in_elem_11 > in_elem_22) begin
      br_c   = BR_Y;
      arg_c  = one_c + e11_c - e00_c - e22_c;
      n_c[0] = ext_add(in_elem_02, in_elem_20, 1'b1);
      n_c[1] = ext_add(in_elem_01, in_elem_10, 1'b0);
      n_c[2] = ext_add(in_elem_12, in_elem_21, 1'b0);
    end else begin
      br_c   = BR_Z;
      arg_c  = one_c + e22_c - e00_c - e11_c;
      n_c[0] = ext_add(in_elem_10, in_elem_01, 1'b1);
      n_c[1] = ext_add(in_elem_02, in_elem_20, 1'b0);
      n_c[2] = ext_add(in_elem_12, in_elem_21, 1'b0);
    end
    bad_c = (arg_c <= 0);
  end

  // ---------------------------------------------------------------------
  // Square root: one root bit per stage, stage 0 is the input register.
  // ---------------------------------------------------------------------
  logic [RAD_W-1:0]  sv_r    [0:SQ_W];
  logic [SQ_W+1:0]   srem_r  [0:SQ_W];
  logic [SQ_W-1:0]   sroot_r [0:SQ_W];
  branch_t           sbr_r   [0:SQ_W];
  logic              sbad_r  [0:SQ_W];
  logic              sval_r  [0:SQ_W];
  logic [NUM_W-1:0]  smag_r  [0:SQ_W][0:2];
  logic              sneg_r  [0:SQ_W][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sval_r[0] <= 1'b0;
    end else if (adv) begin
      sval_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0]    <= bad_c ? '0 : (RAD_W'(arg_c[ARG_W-2:0]) << FRAC_BITS);
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sbr_r[0]   <= br_c;
      sbad_r[0]  <= bad_c;
      for (int i = 0; i < 3; i++) begin
        sneg_r[0][i] <= n_c[i][NUM_W-1];
        smag_r[0][i] <= n_c[i][NUM_W-1] ? NUM_W'(-n_c[i]) : NUM_W'(n_c[i]);
      end
    end
  end

  for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
    logic [SQ_W+1:0] rem_sh, trial;
    logic            ge;
    always_comb begin
      rem_sh = {srem_r[j][SQ_W-1:0], sv_r[j][RAD_W-1 -: 2]};
      trial  = {sroot_r[j], 2'b01};
      ge     = (rem_sh >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sval_r[j+1] <= 1'b0;
      end else if (adv) begin
        sval_r[j+1] <= sval_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sv_r[j+1]    <= sv_r[j] << 2;
        srem_r[j+1]  <= ge ? rem_sh - trial : rem_sh;
        sroot_r[j+1] <= {sroot_r[j][SQ_W-2:0], ge};
        sbr_r[j+1]   <= sbr_r[j];
        sbad_r[j+1]  <= sbad_r[j];
        smag_r[j+1]  <= smag_r[j];
        sneg_r[j+1]  <= sneg_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Division: prepare dividends and the overflow check, then one quotient
  // bit per stage for all three lanes in parallel.
  // ---------------------------------------------------------------------
  logic [DIV_W-1:0] drem_r [0:Q_W][0:2];
  logic [Q_W-1:0]   dq_r   [0:Q_W][0:2];
  logic             dovf_r [0:Q_W][0:2];
  logic             dneg_r [0:Q_W][0:2];
  logic [SQ_W:0]    ds_r   [0:Q_W];
  logic [SQ_W-1:0]  droot_r[0:Q_W];
  branch_t          dbr_r  [0:Q_W];
  logic             dbad_r [0:Q_W];
  logic             dval_r [0:Q_W];

  logic [SQ_W:0]    s_c;
  logic [DIV_W-1:0] num_c [0:2];
  always_comb begin
    s_c = {sroot_r[SQ_W], 1'b0};
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (DIV_W'(smag_r[SQ_W][i]) << FRAC_BITS) + DIV_W'(sroot_r[SQ_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dval_r[0] <= 1'b0;
    end else if (adv) begin
      dval_r[0] <= sval_r[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0]    <= s_c;
      droot_r[0] <= sroot_r[SQ_W];
      dbr_r[0]   <= sbr_r[SQ_W];
      dbad_r[0]  <= sbad_r[SQ_W];
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= num_c[i];
        dq_r[0][i]   <= '0;
        dneg_r[0][i] <= sneg_r[SQ_W][i];
        dovf_r[0][i] <= (CMP_W'(num_c[i]) >= (CMP_W'(s_c) << Q_W));
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int SH = Q_W - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic             ge [0:2];
    always_comb begin
      dsh = CMP_W'(ds_r[k]) << SH;
      for (int i = 0; i < 3; i++) begin
        ge[i] = (CMP_W'(drem_r[k][i]) >= dsh);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dval_r[k+1] <= 1'b0;
      end else if (adv) begin
        dval_r[k+1] <= dval_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[k+1]    <= ds_r[k];
        droot_r[k+1] <= droot_r[k];
        dbr_r[k+1]   <= dbr_r[k];
        dbad_r[k+1]  <= dbad_r[k];
        for (int i = 0; i < 3; i++) begin
          drem_r[k+1][i] <= ge[i] ? DIV_W'(CMP_W'(drem_r[k][i]) - dsh) : drem_r[k][i];
          dq_r[k+1][i]   <= dq_r[k][i] | (ge[i] ? (Q_W'(1) << SH) : '0);
          dovf_r[k+1][i] <= dovf_r[k][i];
          dneg_r[k+1][i] <= dneg_r[k][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sign, saturation, component placement and the output register.
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]           qm_c   [0:2];
  logic signed [ELEM_W-1:0] qv_c   [0:2];
  logic [SQ_W-1:0]          own_c;
  logic signed [ELEM_W-1:0] ownv_c;
  logic signed [ELEM_W-1:0] qw_c, qx_c, qy_c, qz_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm_c[i] = dovf_r[Q_W][i] ? '1 : dq_r[Q_W][i];
      if (dneg_r[Q_W][i]) begin
        qv_c[i] = (qm_c[i] > Q_W'(131072)) ? OUT_MIN : ELEM_W'(-qm_c[i]);
      end else begin
        qv_c[i] = (qm_c[i] > Q_W'(131071)) ? OUT_MAX : ELEM_W'(qm_c[i]);
      end
    end
    own_c  = droot_r[Q_W] >> 1;
    ownv_c = (SQ_W'(own_c) > SQ_W'(131071)) ? OUT_MAX : ELEM_W'(own_c);
    case (dbr_r[Q_W])
      BR_TRACE: begin
        qw_c = ownv_c;  qx_c = qv_c[0]; qy_c = qv_c[1]; qz_c = qv_c[2];
      end
      BR_X: begin
        qw_c = qv_c[0]; qx_c = ownv_c;  qy_c = qv_c[1]; qz_c = qv_c[2];
      end
      BR_Y: begin
        qw_c = qv_c[0]; qx_c = qv_c[1]; qy_c = ownv_c;  qz_c = qv_c[2];
      end
      default: begin
        qw_c = qv_c[0]; qx_c = qv_c[1]; qy_c = qv_c[2]; qz_c = ownv_c;
      end
    endcase
    // A non-positive argument forces all four parts to zero.
    if (dbad_r[Q_W]) begin
      qw_c = '0;
      qx_c = '0;
      qy_c = '0;
      qz_c = '0;
    end
  end

  logic signed [ELEM_W-1:0] qw_r, qx_r, qy_r, qz_r;
  branch_t                  br_r;
  logic                     bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dval_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qw_r  <= qw_c;
      qx_r  <= qx_c;
      qy_r  <= qy_c;
      qz_r  <= qz_c;
      br_r  <= dbr_r[Q_W];
      bad_r <= dbad_r[Q_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_quat_w       = qw_r;
  assign out_quat_x       = qx_r;
  assign out_quat_y       = qy_r;
  assign out_quat_z       = qz_r;
  assign out_branch_taken = br_r;
  assign out_bad_input    = bad_r;

  // A flagged beat carries an all-zero quaternion.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> (qw_r == '0 && qx_r == '0 && qy_r == '0 && qz_r == '0))
    else $error("flagged result carries a non-zero quaternion");

  // While the output is held, the last division stage does not move.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(dval_r[Q_W]) && $stable(dbr_r[Q_W]))
    else $error("pipeline advanced during an output stall");

  // The threshold register comes out of reset at one.
  a_thr_reset: assert property (@(posedge clk)
    !rst_n |=> thr_r == THR_W'(1))
    else $error("trace threshold not at its reset value");

endmodule
